// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FOIU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FOIU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/foiu_pkg.sv
// ---------------------------------------------------------------------------
// foiu_pkg
// Types, constants and the microcode ROM of the four-operation integer unit.
// ---------------------------------------------------------------------------
package foiu_pkg;

	localparam int OPERAND_BITS_DEF = 31;
	localparam int VALUE_BITS       = 32;
	localparam int KIND_BITS        = 2;
	localparam int PCT_BITS         = 7;
	localparam int PCT_SCALE        = 100;
	localparam int UPC_BITS         = 5;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_SUM  = 2'd0,
		KIND_ABS  = 2'd1,
		KIND_PCT  = 2'd2,
		KIND_GCD  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SUM,
		OP_ABS,
		OP_ORDER,
		OP_DBL,
		OP_ADD,
		OP_PCT_OUT,
		OP_P100,
		OP_ERR,
		OP_GSTEP,
		OP_MERGE,
		OP_SHL,
		OP_GOUT
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_X_ZERO,
		C_X_EQ_Y,
		C_Y_ZERO,
		C_GCD_MORE,
		C_K_ZERO,
		C_K_MORE
	} cond_t;

	typedef struct packed {
		op_t                 op;
		cond_t               cond;
		logic [UPC_BITS-1:0] target;
		logic                finish;
	} cw_t;

	typedef struct packed {
		logic load;
		op_t  op;
	} ctrl_t;

	typedef struct packed {
		logic x_zero;
		logic y_zero;
		logic x_eq_y;
		logic gcd_more;
		logic k_zero;
		logic k_more;
	} status_t;

	// Program addresses.
	localparam logic [UPC_BITS-1:0] ADDR_SUM     = 5'd0;
	localparam logic [UPC_BITS-1:0] ADDR_ABS     = 5'd1;
	localparam logic [UPC_BITS-1:0] ADDR_PCT     = 5'd2;
	localparam logic [UPC_BITS-1:0] ADDR_PCT_ZCK = 5'd3;
	localparam logic [UPC_BITS-1:0] ADDR_PCT_ECK = 5'd4;
	localparam logic [UPC_BITS-1:0] ADDR_B6_DBL  = 5'd5;
	localparam logic [UPC_BITS-1:0] ADDR_B6_ADD  = 5'd6;
	localparam logic [UPC_BITS-1:0] ADDR_B5_DBL  = 5'd7;
	localparam logic [UPC_BITS-1:0] ADDR_B5_ADD  = 5'd8;
	localparam logic [UPC_BITS-1:0] ADDR_B4_DBL  = 5'd9;
	localparam logic [UPC_BITS-1:0] ADDR_B3_DBL  = 5'd10;
	localparam logic [UPC_BITS-1:0] ADDR_B2_DBL  = 5'd11;
	localparam logic [UPC_BITS-1:0] ADDR_B2_ADD  = 5'd12;
	localparam logic [UPC_BITS-1:0] ADDR_B1_DBL  = 5'd13;
	localparam logic [UPC_BITS-1:0] ADDR_B0_DBL  = 5'd14;
	localparam logic [UPC_BITS-1:0] ADDR_PCT_OUT = 5'd15;
	localparam logic [UPC_BITS-1:0] ADDR_GCD     = 5'd16;
	localparam logic [UPC_BITS-1:0] ADDR_GSTEP   = 5'd17;
	localparam logic [UPC_BITS-1:0] ADDR_GMERGE  = 5'd18;
	localparam logic [UPC_BITS-1:0] ADDR_GSHL    = 5'd19;
	localparam logic [UPC_BITS-1:0] ADDR_GOUT    = 5'd20;
	localparam logic [UPC_BITS-1:0] ADDR_P100    = 5'd21;
	localparam logic [UPC_BITS-1:0] ADDR_ERR     = 5'd22;
	localparam logic [UPC_BITS-1:0] ADDR_LAST    = ADDR_ERR;

	function automatic cw_t make_cw(input op_t op, input cond_t cond,
			input logic [UPC_BITS-1:0] target, input logic finish);
		cw_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		w.finish = finish;
		return w;
	endfunction

	function automatic logic [UPC_BITS-1:0] foiu_entry(input kind_t kind);
		logic [UPC_BITS-1:0] a;
		case (kind)
			KIND_SUM: a = ADDR_SUM;
			KIND_ABS: a = ADDR_ABS;
			KIND_PCT: a = ADDR_PCT;
			default:  a = ADDR_GCD;
		endcase
		return a;
	endfunction

	// The percentage runs one long division of small*100 by big: a doubling
	// step for every bit of 100 (1100100 in binary) and an add-small step
	// for every one bit.
	function automatic cw_t foiu_rom(input logic [UPC_BITS-1:0] addr);
		cw_t w;
		case (addr)
			ADDR_SUM:     w = make_cw(OP_SUM,     C_NEXT,     ADDR_SUM,    1'b1);
			ADDR_ABS:     w = make_cw(OP_ABS,     C_NEXT,     ADDR_SUM,    1'b1);
			ADDR_PCT:     w = make_cw(OP_ORDER,   C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_PCT_ZCK: w = make_cw(OP_NOP,     C_X_ZERO,   ADDR_ERR,    1'b0);
			ADDR_PCT_ECK: w = make_cw(OP_NOP,     C_X_EQ_Y,   ADDR_P100,   1'b0);
			ADDR_B6_DBL:  w = make_cw(OP_DBL,     C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_B6_ADD:  w = make_cw(OP_ADD,     C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_B5_DBL:  w = make_cw(OP_DBL,     C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_B5_ADD:  w = make_cw(OP_ADD,     C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_B4_DBL:  w = make_cw(OP_DBL,     C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_B3_DBL:  w = make_cw(OP_DBL,     C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_B2_DBL:  w = make_cw(OP_DBL,     C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_B2_ADD:  w = make_cw(OP_ADD,     C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_B1_DBL:  w = make_cw(OP_DBL,     C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_B0_DBL:  w = make_cw(OP_DBL,     C_NEXT,     ADDR_SUM,    1'b0);
			ADDR_PCT_OUT: w = make_cw(OP_PCT_OUT, C_NEXT,     ADDR_SUM,    1'b1);
			ADDR_GCD:     w = make_cw(OP_NOP,     C_Y_ZERO,   ADDR_ERR,    1'b0);
			ADDR_GSTEP:   w = make_cw(OP_GSTEP,   C_GCD_MORE, ADDR_GSTEP,  1'b0);
			ADDR_GMERGE:  w = make_cw(OP_MERGE,   C_K_ZERO,   ADDR_GOUT,   1'b0);
			ADDR_GSHL:    w = make_cw(OP_SHL,     C_K_MORE,   ADDR_GSHL,   1'b0);
			ADDR_GOUT:    w = make_cw(OP_GOUT,    C_NEXT,     ADDR_SUM,    1'b1);
			ADDR_P100:    w = make_cw(OP_P100,    C_NEXT,     ADDR_SUM,    1'b1);
			ADDR_ERR:     w = make_cw(OP_ERR,     C_NEXT,     ADDR_SUM,    1'b1);
			default:      w = make_cw(OP_ERR,     C_NEXT,     ADDR_SUM,    1'b1);
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/foiu_channels.sv
// ---------------------------------------------------------------------------
// foiu channels
// Valid/ready channels for request and response items of the integer unit.
// ---------------------------------------------------------------------------
interface foiu_req_if #(
	parameter int OPERAND_BITS = foiu_pkg::OPERAND_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [foiu_pkg::KIND_BITS-1:0] kind;
	logic [OPERAND_BITS-1:0]        operand_a;
	logic [OPERAND_BITS-1:0]        operand_b;

	modport source (output valid, kind, operand_a, operand_b, input ready);
	modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface foiu_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [foiu_pkg::VALUE_BITS-1:0] value;
	logic                            div_error;

	modport source (output valid, value, div_error, input ready);
	modport sink (input valid, value, div_error, output ready);
endinterface

// File: rtl/core/foiu_datapath.sv
// ---------------------------------------------------------------------------
// foiu_datapath
// Operand registers, compare/subtract logic and the result selection,
// driven one control word at a time by the sequencer.
// ---------------------------------------------------------------------------
module foiu_datapath #(
	parameter int OPERAND_BITS = foiu_pkg::OPERAND_BITS_DEF
) (
	input  logic                            clk,
	input  foiu_pkg::ctrl_t                 ctrl,
	input  logic [OPERAND_BITS-1:0]         operand_a,
	input  logic [OPERAND_BITS-1:0]         operand_b,
	output foiu_pkg::status_t               status,
	output logic [foiu_pkg::VALUE_BITS-1:0] value,
	output logic                            div_error
);
	import foiu_pkg::*;

	localparam int N  = OPERAND_BITS;
	localparam int KW = $clog2(N);

	logic [N-1:0]        x_q, y_q, r_q;
	logic [PCT_BITS-1:0] q_q;
	logic [KW-1:0]       k_q;

	logic          x_ge_y;
	logic [N-1:0]  diff_xy, diff_yx;
	logic [N:0]    sum_w;
	logic [N:0]    pct_t;
	logic          pct_ge;
	logic [N-1:0]  pct_r;
	logic [N-1:0]  gx, gy;
	logic          gk_inc;

	assign x_ge_y  = x_q >= y_q;
	assign diff_xy = x_q - y_q;
	assign diff_yx = y_q - x_q;
	assign sum_w   = {1'b0, x_q} + {1'b0, y_q};

	// Percentage: x holds the larger operand, y the smaller, r the remainder.
	assign pct_t  = (ctrl.op == OP_ADD) ? ({1'b0, r_q} + {1'b0, y_q}) : {r_q, 1'b0};
	assign pct_ge = pct_t >= {1'b0, x_q};
	assign pct_r  = pct_ge ? N'(pct_t - {1'b0, x_q}) : N'(pct_t);

	// One step of the binary GCD: shared factors of two are counted in k.
	always_comb begin
		gx     = x_q;
		gy     = y_q;
		gk_inc = 1'b0;
		if (!x_q[0] && !y_q[0]) begin
			gx     = x_q >> 1;
			gy     = y_q >> 1;
			gk_inc = 1'b1;
		end else if (!x_q[0]) begin
			gx = x_q >> 1;
		end else if (!y_q[0]) begin
			gy = y_q >> 1;
		end else if (x_ge_y) begin
			gx = diff_xy;
		end else begin
			gy = diff_yx;
		end
	end

	assign status.x_zero   = (x_q == '0);
	assign status.y_zero   = (y_q == '0);
	assign status.x_eq_y   = (x_q == y_q);
	assign status.gcd_more = (gx != '0) && (gy != '0);
	assign status.k_zero   = (k_q == '0);
	assign status.k_more   = (k_q != KW'(1));

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= operand_a;
			y_q <= operand_b;
			r_q <= '0;
			q_q <= '0;
			k_q <= '0;
		end else begin
			case (ctrl.op)
				OP_ORDER: begin
					if (!x_ge_y) begin
						x_q <= y_q;
						y_q <= x_q;
					end
				end
				OP_DBL: begin
					r_q <= pct_r;
					q_q <= {q_q[PCT_BITS-2:0], pct_ge};
				end
				OP_ADD: begin
					r_q <= pct_r;
					q_q <= q_q + PCT_BITS'(pct_ge);
				end
				OP_GSTEP: begin
					x_q <= gx;
					y_q <= gy;
					k_q <= k_q + KW'(gk_inc);
				end
				OP_MERGE: x_q <= x_q | y_q;
				OP_SHL: begin
					x_q <= x_q << 1;
					k_q <= k_q - KW'(1);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		value     = '0;
		div_error = 1'b0;
		case (ctrl.op)
			OP_SUM:     value = VALUE_BITS'(sum_w);
			OP_ABS:     value = x_ge_y ? VALUE_BITS'(diff_xy) : VALUE_BITS'(diff_yx);
			OP_PCT_OUT: value = VALUE_BITS'(q_q);
			OP_P100:    value = VALUE_BITS'(PCT_SCALE);
			OP_GOUT:    value = VALUE_BITS'(x_q);
			OP_ERR:     div_error = 1'b1;
			default:    value = '0;
		endcase
	end

endmodule

// File: rtl/core/four_op_integer_unit_top.sv
// ---------------------------------------------------------------------------
// four_op_integer_unit_top
// Integer unit: sum, absolute difference, percentage and GCD of two operands.
// ---------------------------------------------------------------------------
// One item is worked on at a time, by a microcoded sequencer that steps a
// small program through the datapath's compare/subtract logic, one step per
// clock. A sum or a difference is a single step. A percentage is done as a
// long division: the ordering, zero and equality checks, one step per bit
// of 100 and per one bit of it, and the output step. A GCD is a zero check,
// binary-GCD steps while both values stay non-zero, a merge, one shift per
// shared factor of two and the output step. A new item is taken as soon as
// the previous result sits in the output register, and a result waits there
// until it is taken, stalling only the final step of the next item.

`include "assert_macros.svh"

module four_op_integer_unit_top #(
	parameter int OPERAND_BITS = foiu_pkg::OPERAND_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	foiu_req_if.sink    req,
	foiu_rsp_if.source  rsp
);
	import foiu_pkg::*;

	logic                  busy_q;
	logic [UPC_BITS-1:0]   upc_q;
	cw_t                   cw;
	ctrl_t                 ctrl;
	status_t               status;
	logic                  taken;
	logic                  stall;
	logic                  advance;
	logic                  accept;
	logic                  rsp_valid_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  err_q;
	logic [VALUE_BITS-1:0] dp_value;
	logic                  dp_err;

	assign cw      = foiu_rom(upc_q);
	assign accept  = req.valid && req.ready;
	assign stall   = busy_q && cw.finish && rsp_valid_q && !rsp.ready;
	assign advance = busy_q && !stall;

	assign ctrl.load = accept;
	assign ctrl.op   = advance ? cw.op : OP_NOP;

	always_comb begin
		case (cw.cond)
			C_ALWAYS:   taken = 1'b1;
			C_X_ZERO:   taken = status.x_zero;
			C_X_EQ_Y:   taken = status.x_eq_y;
			C_Y_ZERO:   taken = status.y_zero;
			C_GCD_MORE: taken = status.gcd_more;
			C_K_ZERO:   taken = status.k_zero;
			C_K_MORE:   taken = status.k_more;
			default:    taken = 1'b0;
		endcase
	end

	foiu_datapath #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_datapath (
		.clk       (clk),
		.ctrl      (ctrl),
		.operand_a (OPERAND_BITS'(req.operand_a)),
		.operand_b (OPERAND_BITS'(req.operand_b)),
		.status    (status),
		.value     (dp_value),
		.div_error (dp_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= ADDR_SUM;
		end else if (accept) begin
			busy_q <= 1'b1;
			upc_q  <= foiu_entry(kind_t'(req.kind));
		end else if (advance) begin
			if (cw.finish) begin
				busy_q <= 1'b0;
			end
			upc_q <= taken ? cw.target : UPC_BITS'(upc_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && cw.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cw.finish) begin
			value_q <= dp_value;
			err_q   <= dp_err;
		end
	end

	assign req.ready     = !busy_q;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.value     = value_q;
	assign rsp.div_error = err_q;

	`FOIU_ASSERT_NXT(a_busy_after_accept, accept, busy_q && !req.ready, "item accepted but sequencer idle")
	`FOIU_ASSERT_IMP(a_err_value_zero, rsp.valid && rsp.div_error, rsp.value == '0, "error result with non-zero value")
	`FOIU_ASSERT_IMP(a_upc_in_program, busy_q, upc_q <= ADDR_LAST, "microcode address outside the program")
	`FOIU_ASSERT_NXT(a_hold_on_stall, stall, busy_q && $stable(upc_q), "final step left while output blocked")

endmodule
